>>> rtl/dmx_slot_capture_with_loss_detect_core_defines.svh
// Assertion macros for the DMX slot capture RTL
`ifndef DMX_SLOT_CAPTURE_WITH_LOSS_DETECT_CORE_DEFINES_SVH
`define DMX_SLOT_CAPTURE_WITH_LOSS_DETECT_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define DMXSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmxsc assertion failed");

// Next-cycle implication, disabled in reset
`define DMXSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmxsc assertion failed");

`endif

>>> rtl/dmxsc_pkg.sv
// Types and constants for the DMX slot capture block
package dmxsc_pkg;

    localparam int unsigned SlotW      = 10;
    localparam int unsigned ChanW      = 9;
    localparam int unsigned SilenceW   = 16;
    localparam int unsigned ByteW      = 8;
    localparam int unsigned LevelW     = 14;
    localparam int unsigned DataW      = 32;
    localparam int unsigned AddrW      = 3;

    localparam logic [ChanW-1:0]    StartChannelRst = 9'd1;
    localparam logic [SilenceW-1:0] TimeoutRst      = 16'd11494;
    localparam logic [SlotW-1:0]    SlotMax         = 10'd1023;
    localparam logic [SilenceW-1:0] SilenceMax      = 16'hFFFF;

    localparam logic KindByte = 1'b0;
    localparam logic KindTick = 1'b1;

    // register select, taken from paddr[2]
    localparam logic RegStartChannel = 1'b0;
    localparam logic RegTimeoutTicks = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [ByteW-1:0]   data_byte;
        logic               frame_error;
    } in_item_t;

    typedef struct packed {
        logic               level_valid;
        logic [LevelW-1:0]  pwm_level;
        logic               signal_lost;
        logic               lost_event;
        logic               recovered_event;
    } out_item_t;

    typedef struct packed {
        logic [ChanW-1:0]    start_channel;
        logic [SilenceW-1:0] timeout_ticks;
    } cfg_t;

endpackage

>>> rtl/dmxsc_if.sv
// Valid/ready channel interfaces for input items and results
interface dmxsc_in_if
    import dmxsc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [ByteW-1:0] data_byte;
    logic             frame_error;

    modport source (output valid, kind, data_byte, frame_error, input ready);
    modport sink   (input valid, kind, data_byte, frame_error, output ready);
endinterface

interface dmxsc_out_if
    import dmxsc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              level_valid;
    logic [LevelW-1:0] pwm_level;
    logic              signal_lost;
    logic              lost_event;
    logic              recovered_event;

    modport source (output valid, level_valid, pwm_level, signal_lost, lost_event,
                    recovered_event, input ready);
    modport sink   (input valid, level_valid, pwm_level, signal_lost, lost_event,
                    recovered_event, output ready);
endinterface

>>> rtl/dmx_slot_capture_with_loss_detect_core.sv
// Top level of the DMX slot capture block with loss-of-signal detection
//
// Input channel (item): one beat is either a received byte with its framing
// error flag (kind 0) or a timer tick (kind 1). Output channel (result): one
// beat per input beat, carrying the captured 14-bit level when the low slot
// of the configured pair arrives, the current signal-lost flag, and the lost
// and recovered events.
// Path from input beat to result beat: input register, then the update stage
// which writes the slot/silence state and the result register. Throughput:
// one beat per cycle while result.ready is high; the input register and the
// result register each hold a beat, so input is taken while a result waits.
// When the receiver stalls, the result register holds and the input register
// fills, after which item.ready drops until result.ready returns.
// Reset clears the slot index, held high byte, silence count and lost flag,
// and loads start_channel = 1 and timeout_ticks = 11494. Configuration lives
// on the APB port at byte addresses 0 and 4; write it only while idle.
module dmx_slot_capture_with_loss_detect_core
    import dmxsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    dmxsc_in_if.sink         item,
    dmxsc_out_if.source      result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    cfg_t      cfg;
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      advance;
    logic      out_valid;
    out_item_t out_item;
    logic      in_ready;

    dmxsc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register empties whenever the update stage moves
    assign in_ready   = !in_valid_reg || advance;
    assign item.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && item.valid)
        begin
            in_item_reg.kind        <= item.kind;
            in_item_reg.data_byte   <= item.data_byte;
            in_item_reg.frame_error <= item.frame_error;
        end
    end

    dmxsc_update u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (in_valid_reg),
        .item      (in_item_reg),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .out_item  (out_item)
    );

    assign result.valid           = out_valid;
    assign result.level_valid     = out_item.level_valid;
    assign result.pwm_level       = out_item.pwm_level;
    assign result.signal_lost     = out_item.signal_lost;
    assign result.lost_event      = out_item.lost_event;
    assign result.recovered_event = out_item.recovered_event;

endmodule

>>> rtl/dmxsc_cfg.sv
// APB-style configuration registers: start channel and silence timeout
module dmxsc_cfg
    import dmxsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    logic [ChanW-1:0]    start_channel_reg;
    logic [SilenceW-1:0] timeout_ticks_reg;
    logic                wr_en;
    logic                reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    // low address bits ignored, registers sit on 4-byte boundaries
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_channel_reg <= StartChannelRst;
            timeout_ticks_reg <= TimeoutRst;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                RegStartChannel: start_channel_reg <= pwdata[ChanW-1:0];
                RegTimeoutTicks: timeout_ticks_reg <= pwdata[SilenceW-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            RegStartChannel: prdata = {{(DataW-ChanW){1'b0}}, start_channel_reg};
            RegTimeoutTicks: prdata = {{(DataW-SilenceW){1'b0}}, timeout_ticks_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.start_channel = start_channel_reg;
    assign cfg.timeout_ticks = timeout_ticks_reg;

endmodule

>>> rtl/dmxsc_update.sv
// Slot tracking, level capture and loss detection, with the result register
`include "dmx_slot_capture_with_loss_detect_core_defines.svh"

module dmxsc_update
    import dmxsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      fire,
    input  in_item_t  item,
    output logic      advance,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic [SlotW-1:0]    slot_index_reg,    slot_index_next;
    logic [ByteW-1:0]    high_byte_reg,     high_byte_next;
    logic [SilenceW-1:0] silence_count_reg, silence_count_next;
    logic                lost_flag_reg,     lost_flag_next;
    logic                out_valid_reg;
    out_item_t           out_item_reg,      out_item_next;

    logic [SlotW-1:0]    chan_hi;
    logic [SlotW-1:0]    chan_lo;
    logic [SilenceW-1:0] silence_inc;
    logic [15:0]         pair;

    assign chan_hi     = {1'b0, cfg.start_channel};
    assign chan_lo     = chan_hi + 10'd1;
    assign silence_inc = (silence_count_reg == SilenceMax) ? silence_count_reg
                                                           : silence_count_reg + 16'd1;
    assign pair        = {high_byte_reg, item.data_byte};

    always_comb
    begin
        slot_index_next    = slot_index_reg;
        high_byte_next     = high_byte_reg;
        silence_count_next = silence_count_reg;
        lost_flag_next     = lost_flag_reg;
        out_item_next      = '0;

        case (item.kind)
            KindByte:
            begin
                if (item.frame_error)
                begin
                    slot_index_next = '0;
                end
                else
                begin
                    if (slot_index_reg == chan_hi)
                        high_byte_next = item.data_byte;
                    // high and low slots never coincide, so the stored byte is current
                    if (slot_index_reg == chan_lo)
                    begin
                        out_item_next.level_valid = 1'b1;
                        out_item_next.pwm_level   = pair[15:2];
                    end
                    if (lost_flag_reg && slot_index_reg == '0 && item.data_byte == '0)
                    begin
                        lost_flag_next                = 1'b0;
                        out_item_next.recovered_event = 1'b1;
                    end
                    silence_count_next = '0;
                    if (slot_index_reg != SlotMax)
                        slot_index_next = slot_index_reg + 10'd1;
                end
            end
            KindTick:
            begin
                silence_count_next = silence_inc;
                if (silence_inc > cfg.timeout_ticks && !lost_flag_reg)
                begin
                    lost_flag_next           = 1'b1;
                    out_item_next.lost_event = 1'b1;
                    silence_count_next       = '0;
                end
            end
            default: ;
        endcase

        out_item_next.signal_lost = lost_flag_next;
    end

    assign advance = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_index_reg    <= '0;
            high_byte_reg     <= '0;
            silence_count_reg <= '0;
            lost_flag_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= fire;
            if (fire)
            begin
                slot_index_reg    <= slot_index_next;
                high_byte_reg     <= high_byte_next;
                silence_count_reg <= silence_count_next;
                lost_flag_reg     <= lost_flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && fire)
            out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `DMXSC_ASSERT_NOW(a_events_exclusive, clk, rst_n,
        out_valid_reg, !(out_item_reg.lost_event && out_item_reg.recovered_event))
    `DMXSC_ASSERT_NOW(a_lost_event_sets_flag, clk, rst_n,
        out_valid_reg && out_item_reg.lost_event, out_item_reg.signal_lost)
    `DMXSC_ASSERT_NOW(a_recover_clears_flag, clk, rst_n,
        out_valid_reg && out_item_reg.recovered_event, !out_item_reg.signal_lost)
    `DMXSC_ASSERT_NEXT(a_loss_restarts_silence, clk, rst_n,
        advance && fire && out_item_next.lost_event, silence_count_reg == '0)
    `DMXSC_ASSERT_NEXT(a_flag_tracks_result, clk, rst_n,
        advance && fire, lost_flag_reg == out_item_reg.signal_lost)

endmodule
